// ===== sv/spf_pkg.sv =====
package spf_pkg;

    localparam int SYMBOL_W = 8;
    localparam int PERIOD_W = 9;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic fallback;
        logic resolve;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic idx_zero;
        logic hit;
        logic last;
        logic out_hold;
    } t_status;

endpackage

// ===== sv/spf_if.sv =====
interface spf_in_if;
    logic                         valid;
    logic                         ready;
    logic [spf_pkg::SYMBOL_W-1:0] symbol;
    logic                         last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface spf_out_if;
    logic                         valid;
    logic                         ready;
    logic [spf_pkg::PERIOD_W-1:0] period;
    logic                         too_long;

    modport source (output valid, output period, output too_long, input ready);
    modport sink   (input valid, input period, input too_long, output ready);
endinterface

// ===== sv/shortest_period_finder_top.sv =====
// channel   dir   payload                  handshake
// i_in      in    symbol[7:0], last        valid / ready
// o_out     out   period[8:0], too_long    valid / ready
//
// a symbol is accepted in S_IDLE, then compared in S_LOOK; each mismatch
// adds a fallback step (one border ram read each, registered)
// the first symbol of a word and symbols past MAX_WORD skip S_LOOK
// i_rst_n is synchronous; ram contents are not cleared, no sweep is needed
// a word's last symbol waits in place while the previous result is not taken

module shortest_period_finder_top #(
    parameter int MAX_WORD = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spf_in_if.sink     i_in,
    spf_out_if.source  o_out
);

    spf_pkg::t_cmd    cmd;
    spf_pkg::t_status status;

    spf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    spf_datapath #(
        .MAX_WORD (MAX_WORD)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_symbol    (i_in.symbol),
        .i_last      (i_in.last),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .o_period    (o_out.period),
        .o_too_long  (o_out.too_long)
    );

endmodule

// ===== sv/spf_ram.sv =====
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/spf_ctrl.sv =====
module spf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  spf_pkg::t_status i_status,
    output spf_pkg::t_cmd    o_cmd
);

    spf_pkg::t_state r_state;
    spf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            spf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    // first or dropped symbol needs no comparison
                    if (i_status.full || i_status.idx_zero) begin
                        n_state = spf_pkg::S_DONE;
                    end else begin
                        n_state = spf_pkg::S_LOOK;
                    end
                end
            end
            spf_pkg::S_LOOK: begin
                if (i_status.hit) begin
                    o_cmd.resolve = 1'b1;
                    if (!(i_status.last && i_status.out_hold)) begin
                        o_cmd.finish = 1'b1;
                        n_state      = spf_pkg::S_IDLE;
                    end else begin
                        n_state = spf_pkg::S_DONE;
                    end
                end else begin
                    o_cmd.fallback = 1'b1;
                end
            end
            spf_pkg::S_DONE: begin
                if (!(i_status.last && i_status.out_hold)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = spf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/spf_datapath.sv =====
module spf_datapath #(
    parameter int MAX_WORD = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spf_pkg::t_cmd                i_cmd,
    input  logic [spf_pkg::SYMBOL_W-1:0] i_symbol,
    input  logic                         i_last,
    input  logic                         i_out_ready,
    output spf_pkg::t_status             o_status,
    output logic                         o_out_valid,
    output logic [spf_pkg::PERIOD_W-1:0] o_period,
    output logic                         o_too_long
);

    localparam int AW = $clog2(MAX_WORD);
    localparam int CW = $clog2(MAX_WORD + 1);
    localparam int DW = (CW > spf_pkg::PERIOD_W) ? CW : spf_pkg::PERIOD_W;

    logic [spf_pkg::SYMBOL_W-1:0] r_sym;
    logic                         r_last;
    logic [CW-1:0]                r_count;
    logic [AW-1:0]                r_match;
    logic                         r_ovf;
    logic                         r_out_valid;
    logic [spf_pkg::PERIOD_W-1:0] r_period;
    logic                         r_too_long;

    logic [spf_pkg::SYMBOL_W-1:0] ws_q;
    logic [AW-1:0]                bt_q;
    logic [AW-1:0]                ws_raddr;
    logic [AW-1:0]                bt_raddr;
    logic                         full;
    logic                         eq;
    logic [AW-1:0]                m_res;
    logic [AW-1:0]                fm;
    logic [CW-1:0]                count_after;
    logic [DW-1:0]                diff;
    logic                         out_hold;

    assign full     = (r_count == CW'(MAX_WORD));
    assign eq       = (ws_q == r_sym);
    assign m_res    = eq ? r_match + AW'(1) : r_match;
    assign fm       = i_cmd.resolve ? m_res : r_match;
    assign out_hold = r_out_valid && !i_out_ready;

    // on fallback the next candidate comes straight from the border read
    assign ws_raddr = i_cmd.fallback ? bt_q : r_match;
    assign bt_raddr = ws_raddr - AW'(1);

    assign count_after = full ? r_count : r_count + CW'(1);
    assign diff        = DW'(count_after) - DW'(fm);

    spf_ram #(
        .WIDTH (spf_pkg::SYMBOL_W),
        .DEPTH (MAX_WORD)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && !full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (ws_raddr),
        .o_rdata (ws_q)
    );

    spf_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_WORD)
    ) u_border_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && !full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (fm),
        .i_raddr (bt_raddr),
        .o_rdata (bt_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= 1'b0;
            r_count     <= '0;
            r_match     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_last <= i_last;
                if (full) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_count <= '0;
                    r_match <= '0;
                    r_ovf   <= 1'b0;
                end else if (!full) begin
                    r_count <= r_count + CW'(1);
                    r_match <= fm;
                end
            end else if (i_cmd.fallback) begin
                r_match <= bt_q;
            end else if (i_cmd.resolve) begin
                r_match <= m_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sym <= i_symbol;
        end
        if (i_cmd.finish && r_last) begin
            r_period   <= diff[spf_pkg::PERIOD_W-1:0];
            r_too_long <= r_ovf;
        end
    end

    always_comb begin
        o_status          = '0;
        o_status.full     = full;
        o_status.idx_zero = (r_count == '0);
        o_status.hit      = eq || (r_match == '0);
        o_status.last     = r_last;
        o_status.out_hold = out_hold;
    end

    assign o_out_valid = r_out_valid;
    assign o_period    = r_period;
    assign o_too_long  = r_too_long;

endmodule

// ===== sv/spf_checker.sv =====
module spf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_last,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [spf_pkg::PERIOD_W-1:0] i_period,
    input logic                         i_too_long
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] r_pending;
    logic [1:0] n_pending;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // words whose last beat went in and whose result has not yet gone out
    always_comb begin
        n_pending = r_pending;
        if (in_beat && i_in_last) begin
            n_pending = n_pending + 2'd1;
        end
        if (out_beat) begin
            n_pending = n_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_period) && $stable(i_too_long))
        else $error("result changed while stalled");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in_ready)
        else $error("input taken in consecutive cycles");

    a_result_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("result without a finished word");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("too many words in flight");

endmodule

bind shortest_period_finder_top spf_checker u_spf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_period    (o_out.period),
    .i_too_long  (o_out.too_long)
);
